FILE: rtl/afsm_pkg.sv
// Package for the arming and failsafe controller: state codes, request and result types.
package afsm_pkg;

    // Default width of the timestamp arithmetic
    localparam int TIME_WIDTH_DEF = 32;

    // Field widths fixed by the stream payload
    localparam int NOW_W    = 32;
    localparam int HOLD_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int STATE_W  = 3;

    // Packed stream widths, padded to whole bytes
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // Arming hold time after reset, in ms
    localparam logic [HOLD_W-1:0] HOLD_MS_RESET = 16'd1000;

    // Request kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_DISARM = 1'b1;

    typedef enum logic [STATE_W-1:0] {
        ST_BOOT       = 3'd0,
        ST_WAIT       = 3'd1,
        ST_DISARMED   = 3'd2,
        ST_ARMED      = 3'd3,
        ST_FAILSAFE   = 3'd4,
        ST_MOTOR_TEST = 3'd5,
        ST_ERROR      = 3'd6
    } t_state;

    // One accepted request
    typedef struct packed {
        logic              kind;
        logic [NOW_W-1:0]  now_ms;
        logic              radio_connected;
        logic              radio_failsafe;
        logic              arm_switch_engaged;
        logic              sticks_neutral;
        logic              motor_test_requested;
    } t_item;

    // Controller state other than the hold start timestamp
    typedef struct packed {
        t_state             state;
        logic               radio_seen;
        logic               release_lock;
        logic               hold_active;
        logic [COUNT_W-1:0] failsafe_total;
    } t_ctl;

    // One result
    typedef struct packed {
        t_state             robot_state;
        logic [HOLD_W-1:0]  hold_remaining_ms;
        logic [COUNT_W-1:0] failsafe_count;
        logic               rearm_locked;
        logic               motor_test_allowed;
    } t_result;

endpackage

FILE: rtl/arming_failsafe_state_machine_top.sv
// Top level of the robot arming and failsafe controller with stream ports.
// Each request (an update with radio and switch flags and a ms timestamp, or a
// disarm request) yields one result carrying the state after the request. A
// request is accepted every cycle unless a stalled result keeps the input
// register full. The request waits in the input register, and the result
// register loads once the result slot frees, with the controller state updated in
// the same single pass. While a result waits on the output, the input register
// still takes one more request and then holds the input off until the result
// goes. Hold time is measured by a TIME_WIDTH-bit wrapping subtraction of
// timestamps. The hold time register is written through i_cfg_wr_en /
// i_cfg_wr_data and resets to 1000 ms.
module arming_failsafe_state_machine_top #(
    parameter int TIME_WIDTH = afsm_pkg::TIME_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Hold time register write
    input  logic                            i_cfg_wr_en,
    input  logic [afsm_pkg::HOLD_W-1:0]     i_cfg_wr_data,
    // Request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] now_ms, [32] radio_connected, [33] radio_failsafe,
    // [34] arm_switch_engaged, [35] sticks_neutral, [36] motor_test_requested
    input  logic [afsm_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // [0] kind
    input  logic [0:0]                      s_axis_tuser,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] robot_state, [18:3] hold_remaining_ms, [34:19] failsafe_count,
    // [35] rearm_locked, [36] motor_test_allowed
    output logic [afsm_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import afsm_pkg::*;

    localparam int RES_W = $bits(t_result);

    logic [HOLD_W-1:0]     r_hold_ms;
    logic                  r_in_valid;
    t_item                 r_in_item;
    t_ctl                  r_ctl;
    logic [TIME_WIDTH-1:0] r_hold_start;
    logic                  r_out_valid;
    t_result               r_out;

    t_item                 in_item;
    t_ctl                  n_ctl;
    logic [TIME_WIDTH-1:0] n_hold_start;
    t_result               n_out;
    logic                  s_accept;
    logic                  advance;

    // Unpack the request
    always_comb begin
        in_item.kind                 = s_axis_tuser[0];
        in_item.now_ms               = s_axis_tdata[31:0];
        in_item.radio_connected      = s_axis_tdata[32];
        in_item.radio_failsafe       = s_axis_tdata[33];
        in_item.arm_switch_engaged   = s_axis_tdata[34];
        in_item.sticks_neutral       = s_axis_tdata[35];
        in_item.motor_test_requested = s_axis_tdata[36];
    end

    // Handshake: the registered request moves on when the result slot frees
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Hold time register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ms <= HOLD_MS_RESET;
        end else if (i_cfg_wr_en) begin
            r_hold_ms <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_item <= in_item;
        end
    end

    afsm_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_item       (r_in_item),
        .i_ctl        (r_ctl),
        .i_hold_start (r_hold_start),
        .i_hold_ms    (r_hold_ms),
        .o_ctl        (n_ctl),
        .o_hold_start (n_hold_start),
        .o_result     (n_out)
    );

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.state          <= ST_BOOT;
            r_ctl.radio_seen     <= 1'b0;
            r_ctl.release_lock   <= 1'b0;
            r_ctl.hold_active    <= 1'b0;
            r_ctl.failsafe_total <= '0;
            r_hold_start         <= '0;
        end else if (advance) begin
            r_ctl        <= n_ctl;
            r_hold_start <= n_hold_start;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Pack the result, lowest field first
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W-RES_W){1'b0}},
                            r_out.motor_test_allowed,
                            r_out.rearm_locked,
                            r_out.failsafe_count,
                            r_out.hold_remaining_ms,
                            r_out.robot_state};

endmodule

FILE: rtl/afsm_core.sv
// Next-state and result logic of the arming and failsafe controller for one request.
module afsm_core #(
    parameter int TIME_WIDTH = afsm_pkg::TIME_WIDTH_DEF
) (
    input  afsm_pkg::t_item                 i_item,
    input  afsm_pkg::t_ctl                  i_ctl,
    input  logic [TIME_WIDTH-1:0]           i_hold_start,
    input  logic [afsm_pkg::HOLD_W-1:0]     i_hold_ms,
    output afsm_pkg::t_ctl                  o_ctl,
    output logic [TIME_WIDTH-1:0]           o_hold_start,
    output afsm_pkg::t_result               o_result
);
    import afsm_pkg::*;

    localparam int EXT_W = 64;

    logic [EXT_W-1:0]      now_ext;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  hold_done;
    logic                  conn;
    logic                  rfs;
    logic                  sw;
    logic                  seen;
    t_state                target;
    t_ctl                  n_ctl;
    logic [TIME_WIDTH-1:0] n_start;

    // Timestamp reduced to the arithmetic width; elapsed time wraps there
    assign now_ext   = {{(EXT_W-NOW_W){1'b0}}, i_item.now_ms};
    assign now_t     = now_ext[TIME_WIDTH-1:0];
    assign elapsed   = now_t - i_hold_start;
    assign hold_done = elapsed >= {{(TIME_WIDTH-HOLD_W){1'b0}}, i_hold_ms};

    assign conn = i_item.radio_connected;
    assign rfs  = i_item.radio_failsafe;
    assign sw   = i_item.arm_switch_engaged;
    assign seen = i_ctl.radio_seen | conn;

    // Transition rules
    always_comb begin
        n_ctl   = i_ctl;
        n_start = i_hold_start;
        target  = i_ctl.state;
        if (i_item.kind == KIND_DISARM) begin
            if (i_ctl.state == ST_ARMED || i_ctl.state == ST_MOTOR_TEST) begin
                target = ST_DISARMED;
            end
        end else begin
            n_ctl.radio_seen = seen;
            if (!sw) begin
                n_ctl.release_lock = 1'b0;
            end
            if ((!conn || rfs) && seen) begin
                target = ST_FAILSAFE;
            end else begin
                unique case (i_ctl.state)
                    ST_BOOT: begin
                        target = ST_WAIT;
                    end
                    ST_WAIT: begin
                        if (conn) target = ST_DISARMED;
                    end
                    ST_FAILSAFE: begin
                        if (conn && !sw) target = ST_DISARMED;
                    end
                    ST_DISARMED: begin
                        if (i_item.motor_test_requested && !rfs && !sw) begin
                            target = ST_MOTOR_TEST;
                        end else if (sw && i_item.sticks_neutral && !n_ctl.release_lock) begin
                            if (!i_ctl.hold_active) begin
                                n_ctl.hold_active = 1'b1;
                                n_start           = now_t;
                            end else if (hold_done) begin
                                target = ST_ARMED;
                            end
                        end else begin
                            n_ctl.hold_active = 1'b0;
                        end
                    end
                    ST_ARMED: begin
                        if (!sw) target = ST_DISARMED;
                    end
                    ST_MOTOR_TEST: begin
                        if (!i_item.motor_test_requested || sw) target = ST_DISARMED;
                    end
                    default: begin
                        target = i_ctl.state;
                    end
                endcase
            end
        end

        // A real transition drops the hold; entering failsafe counts and locks
        if (target != i_ctl.state) begin
            n_ctl.state       = target;
            n_ctl.hold_active = 1'b0;
            if (target == ST_FAILSAFE) begin
                n_ctl.failsafe_total = i_ctl.failsafe_total + COUNT_W'(1);
                n_ctl.release_lock   = 1'b1;
            end
        end

        // A disarm request always sets the re-arm lock
        if (i_item.kind == KIND_DISARM) begin
            n_ctl.release_lock = 1'b1;
        end
    end

    // Result fields; a hold started by this request has no elapsed time yet
    always_comb begin
        o_result.robot_state    = n_ctl.state;
        o_result.failsafe_count = n_ctl.failsafe_total;
        o_result.rearm_locked   = n_ctl.release_lock;
        o_result.motor_test_allowed = (n_ctl.state == ST_DISARMED) && !rfs && !sw;
        if (!n_ctl.hold_active || !i_ctl.hold_active) begin
            o_result.hold_remaining_ms = i_hold_ms;
        end else if (hold_done) begin
            o_result.hold_remaining_ms = '0;
        end else begin
            o_result.hold_remaining_ms = i_hold_ms - elapsed[HOLD_W-1:0];
        end
    end

    assign o_ctl        = n_ctl;
    assign o_hold_start = n_start;

endmodule

FILE: rtl/afsm_checker.sv
// Port-level assertions for the arming and failsafe controller, bound to the top level.
module afsm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [afsm_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import afsm_pkg::*;

    logic [STATE_W-1:0] res_state;
    logic               res_locked;
    logic               res_mt_allowed;

    assign res_state      = m_axis_tdata[2:0];
    assign res_locked     = m_axis_tdata[35];
    assign res_mt_allowed = m_axis_tdata[36];

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The error code and the unused code never show up
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> res_state <= ST_MOTOR_TEST)
        else $error("unreachable state reported");

    // Motor test is only offered while disarmed
    a_mt_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res_mt_allowed |-> res_state == ST_DISARMED)
        else $error("motor test allowed outside disarmed");

    // Armed is only reached and kept without the re-arm lock
    a_armed_unlocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res_state == ST_ARMED |-> !res_locked)
        else $error("armed while re-arm lock set");

endmodule

bind arming_failsafe_state_machine_top afsm_checker u_afsm_checker (.*);
